>>> rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and helper functions of the escape-time iterator.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // Number format and iteration counter
    localparam int FRAC_BITS = 56;
    localparam int ITER_BITS = 16;
    localparam int ZW        = 64;
    localparam int HW        = ZW / 2;
    localparam int PW        = 2 * ZW;
    localparam int CNT_W     = ITER_BITS + 1;
    localparam int CFG_W     = 16;

    typedef logic signed [ZW-1:0]    z_t;
    typedef logic        [ZW-1:0]    mag_t;
    typedef logic        [HW-1:0]    half_t;
    typedef logic        [ZW-1:0]    pp_t;
    typedef logic signed [PW-1:0]    wide_t;
    typedef logic        [PW-1:0]    uwide_t;
    typedef logic        [ITER_BITS-1:0] lim_t;
    typedef logic        [CNT_W-1:0] cnt_t;
    typedef logic        [CFG_W-1:0] cfg_t;

    // Escape radius squared: 16.0 in the product format Q.2F
    localparam uwide_t RADIUS = uwide_t'(1) << (4 + 2 * FRAC_BITS);

    // Register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    typedef logic [ADDR_W-3:0] reg_idx_t;
    localparam reg_idx_t REG_MAX_ITER   = reg_idx_t'(0);
    localparam cfg_t     MAX_ITER_RESET = cfg_t'(255);

    // Multiply sequencer: three products, four partial products each
    localparam int MUL_PARTS = 4;
    typedef logic [3:0] stp_t;
    typedef logic [1:0] prod_t;
    localparam prod_t PROD_RR = 2'd0;
    localparam prod_t PROD_II = 2'd1;
    localparam prod_t PROD_RI = 2'd2;
    localparam stp_t  STP_ISSUE_END = stp_t'(3 * MUL_PARTS);
    localparam stp_t  STP_RR_DONE   = stp_t'(MUL_PARTS + 1);
    localparam stp_t  STP_II_DONE   = stp_t'(2 * MUL_PARTS + 1);
    localparam stp_t  STP_RI_DONE   = stp_t'(3 * MUL_PARTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_MUL,
        ST_EVAL,
        ST_UPDATE,
        ST_FIN
    } state_t;

    // Control of the multiply-accumulate unit
    typedef struct packed {
        logic       issue;
        logic       first;
        logic [1:0] shift;
    } mac_ctrl_t;

    // Finished result of one item
    typedef struct packed {
        cnt_t count;
        logic flag;
    } res_t;

    // Magnitude of a two's complement value
    function automatic mag_t mag64(input z_t v);
        mag_t r;
        r = v[ZW-1] ? (~mag_t'(v) + mag_t'(1)) : mag_t'(v);
        return r;
    endfunction

    // Clamp a wide value to the 64-bit range
    function automatic z_t sat64(input wide_t v);
        z_t r;
        if ((&v[PW-1:ZW-1]) || !(|v[PW-1:ZW-1]))
            r = v[ZW-1:0];
        else if (v[PW-1])
            r = {1'b1, {(ZW-1){1'b0}}};
        else
            r = {1'b0, {(ZW-1){1'b1}}};
        return r;
    endfunction

endpackage

>>> rtl/mbe_regs.sv
// ----------------------------------------------------------------------------
// mbe_regs
// APB register file holding the iteration limit.
// ----------------------------------------------------------------------------
module mbe_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]   paddr,
    input  logic [mbe_pkg::DATA_W-1:0]   pwdata,
    output logic [mbe_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output mbe_pkg::cfg_t                iter_limit
);

    mbe_pkg::cfg_t     max_iter_reg;
    mbe_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[mbe_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    // Write the limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= mbe_pkg::MAX_ITER_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mbe_pkg::REG_MAX_ITER: max_iter_reg <= pwdata[mbe_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            mbe_pkg::REG_MAX_ITER: prdata = mbe_pkg::DATA_W'(max_iter_reg);
            default:               prdata = '0;
        endcase
    end

    assign iter_limit = max_iter_reg;

endmodule

>>> rtl/mbe_mac.sv
// ----------------------------------------------------------------------------
// mbe_mac
// Shared 32x32 multiplier with registered product and a 128-bit accumulator
// that assembles 64x64 magnitude products from four partial products.
// ----------------------------------------------------------------------------
module mbe_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  mbe_pkg::mac_ctrl_t  ctrl,
    input  mbe_pkg::half_t      a_half,
    input  mbe_pkg::half_t      b_half,
    output mbe_pkg::uwide_t     acc
);

    mbe_pkg::pp_t    pp_reg;
    logic            pp_vld_reg;
    logic            pp_first_reg;
    logic [1:0]      pp_shift_reg;
    mbe_pkg::uwide_t acc_reg;
    mbe_pkg::uwide_t acc_next;
    mbe_pkg::uwide_t pp_aligned;

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_vld_reg <= 1'b0;
        end
        else
        begin
            pp_vld_reg <= ctrl.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            pp_reg       <= mbe_pkg::pp_t'(a_half) * mbe_pkg::pp_t'(b_half);
            pp_first_reg <= ctrl.first;
            pp_shift_reg <= ctrl.shift;
        end
    end

    // Align the partial product by its half-word weight
    always_comb
    begin
        case (pp_shift_reg)
            2'd0:    pp_aligned = mbe_pkg::uwide_t'(pp_reg);
            2'd1:    pp_aligned = mbe_pkg::uwide_t'(pp_reg) << mbe_pkg::HW;
            default: pp_aligned = mbe_pkg::uwide_t'(pp_reg) << (2 * mbe_pkg::HW);
        endcase
    end

    // Accumulate stage; the first partial restarts the sum
    assign acc_next = (pp_first_reg ? '0 : acc_reg) + pp_aligned;

    always_ff @(posedge clk)
    begin
        if (pp_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/mbe_core.sv
// ----------------------------------------------------------------------------
// mbe_core
// Sequencer and orbit datapath: runs z = z^2 + c through the shared
// multiply-accumulate unit, tests escape and limit, and holds the result.
// ----------------------------------------------------------------------------
module mbe_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mbe_pkg::z_t     c_real,
    input  mbe_pkg::z_t     c_imag,
    input  mbe_pkg::cfg_t   iter_limit,
    output logic            res_valid,
    output mbe_pkg::res_t   res,
    input  logic            res_take
);

    mbe_pkg::state_t    state_reg;
    mbe_pkg::state_t    state_next;
    mbe_pkg::stp_t      stp_reg;
    mbe_pkg::stp_t      stp_next;
    mbe_pkg::cnt_t      cnt_reg;
    mbe_pkg::cnt_t      cnt_next;
    logic               flag_reg;
    logic               flag_next;

    mbe_pkg::z_t        cr_reg;
    mbe_pkg::z_t        ci_reg;
    mbe_pkg::z_t        zr_reg;
    mbe_pkg::z_t        zi_reg;
    mbe_pkg::mag_t      mr_reg;
    mbe_pkg::mag_t      mi_reg;
    logic               sgn_reg;
    mbe_pkg::uwide_t    sr_reg;
    mbe_pkg::uwide_t    si_reg;
    mbe_pkg::wide_t     pri_reg;
    mbe_pkg::wide_t     diff_reg;
    mbe_pkg::lim_t      limit_reg;

    mbe_pkg::mac_ctrl_t mac_ctrl;
    mbe_pkg::half_t     a_half;
    mbe_pkg::half_t     b_half;
    mbe_pkg::uwide_t    acc;
    mbe_pkg::mag_t      a_op;
    mbe_pkg::mag_t      b_op;
    mbe_pkg::prod_t     prod;

    logic [mbe_pkg::PW:0] mag_sum;
    logic               escape;
    logic               over;
    mbe_pkg::wide_t     nr_wide;
    mbe_pkg::wide_t     ni_wide;
    mbe_pkg::z_t        zr_new;
    mbe_pkg::z_t        zi_new;
    logic               hit;
    logic               accept;

    assign accept = in_valid && in_ready;

    mbe_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_half (a_half),
        .b_half (b_half),
        .acc    (acc)
    );

    // Escape and limit tests
    assign mag_sum = {1'b0, sr_reg} + {1'b0, si_reg};
    assign escape  = mag_sum > {1'b0, mbe_pkg::RADIUS};
    assign over    = cnt_reg > mbe_pkg::cnt_t'(limit_reg);

    // Next z, rescaled and clamped
    assign nr_wide = (diff_reg >>> mbe_pkg::FRAC_BITS) + mbe_pkg::wide_t'(cr_reg);
    assign ni_wide = (pri_reg >>> (mbe_pkg::FRAC_BITS - 1)) + mbe_pkg::wide_t'(ci_reg);
    assign zr_new  = mbe_pkg::sat64(nr_wide);
    assign zi_new  = mbe_pkg::sat64(ni_wide);
    assign hit     = (zr_new == cr_reg) && (zi_new == ci_reg)
                     && (cnt_reg >= mbe_pkg::cnt_t'(limit_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbe_pkg::ST_IDLE:   if (in_valid) state_next = mbe_pkg::ST_MAG;
            mbe_pkg::ST_MAG:    state_next = mbe_pkg::ST_MUL;
            mbe_pkg::ST_MUL:    if (stp_reg == mbe_pkg::STP_RI_DONE)
                                    state_next = mbe_pkg::ST_EVAL;
            mbe_pkg::ST_EVAL:   state_next = (escape || over) ? mbe_pkg::ST_FIN
                                                              : mbe_pkg::ST_UPDATE;
            mbe_pkg::ST_UPDATE: state_next = hit ? mbe_pkg::ST_FIN : mbe_pkg::ST_MAG;
            mbe_pkg::ST_FIN:    if (res_take) state_next = mbe_pkg::ST_IDLE;
            default:            state_next = mbe_pkg::ST_IDLE;
        endcase
    end

    // Step, count and flag updates
    always_comb
    begin
        stp_next  = stp_reg;
        cnt_next  = cnt_reg;
        flag_next = flag_reg;
        if (accept)
        begin
            cnt_next  = '0;
            flag_next = 1'b0;
        end
        if (state_reg == mbe_pkg::ST_MAG)
            stp_next = '0;
        else if (state_reg == mbe_pkg::ST_MUL)
            stp_next = stp_reg + mbe_pkg::stp_t'(1);
        if (state_reg == mbe_pkg::ST_UPDATE)
        begin
            if (hit)
                flag_next = 1'b1;
            else
                cnt_next = cnt_reg + mbe_pkg::cnt_t'(1);
        end
    end

    // Outputs: handshakes and multiplier control
    always_comb
    begin
        in_ready       = (state_reg == mbe_pkg::ST_IDLE);
        res_valid      = (state_reg == mbe_pkg::ST_FIN);
        prod           = stp_reg[3:2];
        mac_ctrl.issue = (state_reg == mbe_pkg::ST_MUL) && (stp_reg < mbe_pkg::STP_ISSUE_END);
        mac_ctrl.first = (stp_reg[1:0] == 2'd0);
        mac_ctrl.shift = {1'b0, stp_reg[0]} + {1'b0, stp_reg[1]};
    end

    // Operand selection for the current product
    always_comb
    begin
        a_op = (prod == mbe_pkg::PROD_II) ? mi_reg : mr_reg;
        b_op = (prod == mbe_pkg::PROD_RR) ? mr_reg : mi_reg;
        a_half = stp_reg[0] ? a_op[mbe_pkg::ZW-1:mbe_pkg::HW] : a_op[mbe_pkg::HW-1:0];
        b_half = stp_reg[1] ? b_op[mbe_pkg::ZW-1:mbe_pkg::HW] : b_op[mbe_pkg::HW-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbe_pkg::ST_IDLE;
            stp_reg   <= '0;
            cnt_reg   <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stp_reg   <= stp_next;
            cnt_reg   <= cnt_next;
            flag_reg  <= flag_next;
        end
    end

    // Orbit datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cr_reg    <= c_real;
            ci_reg    <= c_imag;
            zr_reg    <= c_real;
            zi_reg    <= c_imag;
            limit_reg <= mbe_pkg::lim_t'(iter_limit);
        end
        if (state_reg == mbe_pkg::ST_MAG)
        begin
            mr_reg  <= mbe_pkg::mag64(zr_reg);
            mi_reg  <= mbe_pkg::mag64(zi_reg);
            sgn_reg <= zr_reg[mbe_pkg::ZW-1] ^ zi_reg[mbe_pkg::ZW-1];
        end
        if (state_reg == mbe_pkg::ST_MUL)
        begin
            if (stp_reg == mbe_pkg::STP_RR_DONE)
                sr_reg <= acc;
            if (stp_reg == mbe_pkg::STP_II_DONE)
                si_reg <= acc;
            if (stp_reg == mbe_pkg::STP_RI_DONE)
                pri_reg <= sgn_reg ? -acc : acc;
        end
        if (state_reg == mbe_pkg::ST_EVAL)
            diff_reg <= sr_reg - si_reg;
        if (state_reg == mbe_pkg::ST_UPDATE)
        begin
            zr_reg <= zr_new;
            zi_reg <= zi_new;
        end
    end

    assign res.count = cnt_reg;
    assign res.flag  = flag_reg;

    // Count never passes one beyond the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != mbe_pkg::ST_IDLE
        |-> cnt_reg <= mbe_pkg::cnt_t'(limit_reg) + mbe_pkg::cnt_t'(1))
        else $error("iteration count beyond limit plus one");

    // A return to start is only reported at the limit
    a_flag_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbe_pkg::ST_FIN && flag_reg
        |-> cnt_reg == mbe_pkg::cnt_t'(limit_reg))
        else $error("return flag away from limit");

    // The multiply sequence ends at its last latch step
    a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbe_pkg::ST_MUL |-> stp_reg <= mbe_pkg::STP_RI_DONE)
        else $error("multiply step counter overran");

    // A result not taken is held
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbe_pkg::ST_FIN && !res_take
        |=> state_reg == mbe_pkg::ST_FIN && $stable(cnt_reg) && $stable(flag_reg))
        else $error("pending result lost");

endmodule

>>> rtl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration of one point c in signed Q8.56 fixed point.
//
// Input channel (in_valid/in_ready) takes c_real and c_imag; output channel
// (out_valid/out_ready) returns iteration_count and returned_to_start, one
// item per input item. The APB port holds the iteration limit (address 0x0,
// reset 255), to be written only while the block is idle; the block does not enforce this.
// One item is worked at a time; in_ready is high only while idle. Each
// orbit step runs magnitudes, twelve 32x32 partial products through the
// single shared multiplier plus accumulate, escape test and update.
// The output register lets a new item be accepted while a result waits;
// if the receiver still stalls when the next item finishes, that item is
// held in the core until the output register frees.
// Reset clears the sequencer and the output valid and loads the limit 255.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]           paddr,
    input  logic [mbe_pkg::DATA_W-1:0]           pwdata,
    output logic [mbe_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [mbe_pkg::ZW-1:0]        c_real,
    input  logic signed [mbe_pkg::ZW-1:0]        c_imag,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mbe_pkg::ITER_BITS:0]          iteration_count,
    output logic                                 returned_to_start
);

    mbe_pkg::cfg_t  iter_limit;
    logic           res_valid;
    logic           res_take;
    mbe_pkg::res_t  res;
    logic           out_valid_reg;
    mbe_pkg::cnt_t  count_reg;
    logic           flag_reg;

    mbe_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .iter_limit     (iter_limit)
    );

    mbe_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .c_real         (c_real),
        .c_imag         (c_imag),
        .iter_limit     (iter_limit),
        .res_valid      (res_valid),
        .res            (res),
        .res_take       (res_take)
    );

    // Take a result when the output register is empty or draining
    assign res_take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            count_reg <= res.count;
            flag_reg  <= res.flag;
        end
    end

    assign out_valid         = out_valid_reg;
    assign iteration_count   = count_reg;
    assign returned_to_start = flag_reg;

endmodule

>>> tb/sv/escape_time_checker.sv
// ----------------------------------------------------------------------------
// escape_time_checker
// Watches the point and result channels and the register port of the
// escape-time iterator. It keeps its own copy of the iteration limit and
// works out the escape count and the return-to-start flag of every accepted
// point. Each accepted result is then compared with the oldest of these.
// Register reads are checked against the tracked limit.
// ----------------------------------------------------------------------------
module escape_time_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0] paddr,
    input  logic [mbe_pkg::DATA_W-1:0] pwdata,
    input  logic [mbe_pkg::DATA_W-1:0] prdata,
    input  logic                       pready,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  mbe_pkg::z_t                c_real,
    input  mbe_pkg::z_t                c_imag,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  mbe_pkg::cnt_t              iteration_count,
    input  logic                       returned_to_start,
    output int                         mismatches,
    output int                         pending,
    output int                         returns_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mbe_pkg::ADDR_W-1:0] LIMIT_ADDR =
        mbe_pkg::ADDR_W'(mbe_pkg::REG_MAX_ITER) << 2;
    localparam mbe_pkg::z_t Z_TOP    = {1'b0, {(mbe_pkg::ZW-1){1'b1}}};
    localparam mbe_pkg::z_t Z_BOTTOM = {1'b1, {(mbe_pkg::ZW-1){1'b0}}};

    typedef struct packed {
        mbe_pkg::cnt_t count;
        logic          flag;
    } escape_t;

    escape_t       expected_escapes[$];
    mbe_pkg::cfg_t limit_now = mbe_pkg::MAX_ITER_RESET;

    // Clamp a wide sum to the Q8.56 range
    function automatic mbe_pkg::z_t clamp_q856(input mbe_pkg::wide_t v);
        if (v > mbe_pkg::wide_t'(Z_TOP))
            return Z_TOP;
        if (v < mbe_pkg::wide_t'(Z_BOTTOM))
            return Z_BOTTOM;
        return v[mbe_pkg::ZW-1:0];
    endfunction

    // Run the orbit of c and return its escape count and flag
    function automatic escape_t escape_time(input mbe_pkg::z_t cr, input mbe_pkg::z_t ci,
                                            input mbe_pkg::cfg_t limit_cfg);
        mbe_pkg::z_t     zr;
        mbe_pkg::z_t     zi;
        mbe_pkg::wide_t  wr;
        mbe_pkg::wide_t  wi;
        mbe_pkg::wide_t  sq_r;
        mbe_pkg::wide_t  sq_i;
        mbe_pkg::uwide_t mag2;
        mbe_pkg::lim_t   lim;
        int unsigned     steps;
        logic            hit;
        logic            done;
        escape_t         res;
        zr    = cr;
        zi    = ci;
        lim   = mbe_pkg::lim_t'(limit_cfg);
        steps = 0;
        hit   = 1'b0;
        done  = 1'b0;
        while (!done)
        begin
            wr   = mbe_pkg::wide_t'(zr);
            wi   = mbe_pkg::wide_t'(zi);
            sq_r = wr * wr;
            sq_i = wi * wi;
            mag2 = mbe_pkg::uwide_t'(sq_r) + mbe_pkg::uwide_t'(sq_i);
            if (mag2 > mbe_pkg::RADIUS || steps > lim)
                done = 1'b1;
            else
            begin
                // wr still holds the old real part for the cross product
                zr = clamp_q856(((sq_r - sq_i) >>> mbe_pkg::FRAC_BITS)
                                + mbe_pkg::wide_t'(cr));
                zi = clamp_q856(((wr * wi) >>> (mbe_pkg::FRAC_BITS - 1))
                                + mbe_pkg::wide_t'(ci));
                if (zr == cr && zi == ci && steps >= lim)
                begin
                    hit  = 1'b1;
                    done = 1'b1;
                end
                else
                    steps++;
            end
        end
        res.count = mbe_pkg::cnt_t'(steps);
        res.flag  = hit;
        return res;
    endfunction

    // Track the limit, queue predictions and compare results
    always @(posedge clk or negedge rst_n)
    begin
        escape_t got;
        escape_t want;
        if (!rst_n)
        begin
            limit_now = mbe_pkg::MAX_ITER_RESET;
            expected_escapes.delete();
            mismatches   = 0;
            returns_seen = 0;
        end
        else
        begin
            // Retire the result item first: it belongs to an older point
            if (out_valid && out_ready)
            begin
                got.count = iteration_count;
                got.flag  = returned_to_start;
                if (got.flag)
                    returns_seen++;
                if (expected_escapes.size() == 0)
                begin
                    $error("result item with no point pending: iteration_count %0d, returned_to_start %0d",
                           got.count, got.flag);
                    mismatches++;
                end
                else
                begin
                    want = expected_escapes.pop_front();
                    if (got.count !== want.count)
                    begin
                        $error("iteration_count: expected %0d, actual %0d", want.count, got.count);
                        mismatches++;
                    end
                    if (got.flag !== want.flag)
                    begin
                        $error("returned_to_start: expected %0d, actual %0d", want.flag, got.flag);
                        mismatches++;
                    end
                end
            end

            // Predict each accepted point item
            if (in_valid && in_ready)
                expected_escapes.push_back(escape_time(c_real, c_imag, limit_now));

            // Follow writes to the limit and check reads of it
            if (psel && penable && pready && paddr == LIMIT_ADDR)
            begin
                if (pwrite)
                    limit_now = pwdata[mbe_pkg::CFG_W-1:0];
                else if (prdata[mbe_pkg::CFG_W-1:0] !== limit_now)
                begin
                    $error("iter_limit: expected %0d, actual %0d", limit_now,
                           prdata[mbe_pkg::CFG_W-1:0]);
                    mismatches++;
                end
            end
        end
        pending = expected_escapes.size();
    end

endmodule

>>> tb/sv/mandelbrot_escape_time_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// Drives points c into the escape-time iterator and sweeps the iteration
// limit from 0 to 65535 over the register port. A short directed set covers
// the format extremes, the radius boundary, orbits that close back on c and
// the zero limit; random points follow, mostly inside the interesting box.
// The sender idles in bursts and the receiver stalls in its own pattern.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int SWEEP_PHASES   = 14;
    localparam int SWEEP_POINTS   = 105;

    localparam logic [mbe_pkg::ADDR_W-1:0] LIMIT_ADDR =
        mbe_pkg::ADDR_W'(mbe_pkg::REG_MAX_ITER) << 2;
    localparam mbe_pkg::z_t Q_ONE    = mbe_pkg::z_t'(1) << mbe_pkg::FRAC_BITS;
    localparam mbe_pkg::z_t Z_TOP    = {1'b0, {(mbe_pkg::ZW-1){1'b1}}};
    localparam mbe_pkg::z_t Z_BOTTOM = {1'b1, {(mbe_pkg::ZW-1){1'b0}}};

    typedef enum int {
        PT_WILD,
        PT_BOX,
        PT_ORBIT,
        PT_FAR
    } point_kind_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mbe_pkg::ADDR_W-1:0]    paddr;
    logic [mbe_pkg::DATA_W-1:0]    pwdata;
    logic [mbe_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    mbe_pkg::z_t                   c_real;
    mbe_pkg::z_t                   c_imag;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    mbe_pkg::cnt_t                 iteration_count;
    logic                          returned_to_start;

    int mismatches;
    int pending_results;
    int returns_seen;
    int points_sent = 0;
    int limits_set = 0;
    int burst_left = 0;
    int ready_mode = 0;
    int ready_left = 0;
    int stall_cycles = 0;

    mbe_pkg::cfg_t sweep_limits [SWEEP_PHASES];

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    mandelbrot_escape_time dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .c_real            (c_real),
        .c_imag            (c_imag),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .iteration_count   (iteration_count),
        .returned_to_start (returned_to_start)
    );

    escape_time_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .c_real            (c_real),
        .c_imag            (c_imag),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .iteration_count   (iteration_count),
        .returned_to_start (returned_to_start),
        .mismatches        (mismatches),
        .pending           (pending_results),
        .returns_seen      (returns_seen)
    );

    // Stall the receiver: switch between four stall patterns, each held for a random run
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(1, 150);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 5) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Count cycles with no item moving on any port
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic mbe_pkg::z_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // Pick a point of the given kind
    function automatic void pick_point(input point_kind_t kind, output mbe_pkg::z_t re,
                                       output mbe_pkg::z_t im);
        mbe_pkg::z_t tiny_r;
        mbe_pkg::z_t tiny_i;
        tiny_r = rand_word() >>> 40;
        tiny_i = rand_word() >>> 40;
        case (kind)
            PT_WILD:
            begin
                re = rand_word();
                im = rand_word();
            end
            PT_BOX:
            begin
                re = rand_word() >>> $urandom_range(5, 8);
                im = rand_word() >>> $urandom_range(5, 8);
            end
            PT_ORBIT:
            begin
                case ($urandom_range(0, 7))
                    0:       begin re = '0;                   im = '0;     end
                    1:       begin re = -Q_ONE;               im = '0;     end
                    2:       begin re = -(2 * Q_ONE);         im = '0;     end
                    3:       begin re = '0; im = $urandom_range(0, 1) ? Q_ONE : -Q_ONE; end
                    4:       begin re = tiny_r;               im = tiny_i; end
                    5:       begin re = -Q_ONE + tiny_r;      im = tiny_i; end
                    6:       begin re = (Q_ONE / 4) + tiny_r; im = tiny_i; end
                    default: begin re = -(3 * Q_ONE / 4);     im = tiny_i; end
                endcase
            end
            default:
            begin
                // Keep |c| at 2.25 or more so the orbit leaves within a few steps
                if ($urandom_range(0, 1))
                begin
                    re = rand_word();
                    re[mbe_pkg::ZW-2] = ~re[mbe_pkg::ZW-1];
                    im = rand_word();
                end
                else
                begin
                    re = (9 * Q_ONE / 4) + (rand_word() & (Q_ONE - 1));
                    if ($urandom_range(0, 1))
                        re = -re;
                    im = rand_word() >>> 9;
                end
            end
        endcase
    endfunction

    // Offer one point item, hold it until accepted, then idle between bursts
    task automatic push_point(input mbe_pkg::z_t re, input mbe_pkg::z_t im);
        int gap;
        c_real   = re;
        c_imag   = im;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        points_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid = 1'b0;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic push_random(input int count, input logic far_only);
        mbe_pkg::z_t re;
        mbe_pkg::z_t im;
        int          roll;
        point_kind_t kind;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (far_only)
                kind = PT_FAR;
            else if (roll < 15)
                kind = PT_WILD;
            else if (roll < 75)
                kind = PT_BOX;
            else if (roll < 90)
                kind = PT_ORBIT;
            else
                kind = PT_FAR;
            pick_point(kind, re, im);
            push_point(re, im);
        end
    endtask

    // Drop valid and wait until every result item has come back
    task automatic quiesce();
        in_valid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // One register access: setup cycle, then access cycle until pready
    task automatic apb_xfer(input logic wr, input logic [mbe_pkg::DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = LIMIT_ADDR;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Change the limit while idle and read it back; upper data bits are noise
    task automatic set_limit(input mbe_pkg::cfg_t limit);
        logic [mbe_pkg::DATA_W-1:0] data;
        quiesce();
        data = $urandom;
        data[mbe_pkg::CFG_W-1:0] = limit;
        apb_xfer(1'b1, data);
        apb_xfer(1'b0, '0);
        limits_set++;
    endtask

    initial
    begin
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        c_real   = '0;
        c_imag   = '0;
        sweep_limits = '{0, 1, 2, 3, 4, 5, 7, 8, 12, 16, 23, 32, 47, 0};
        sweep_limits[SWEEP_PHASES-1] = mbe_pkg::cfg_t'($urandom_range(0, 63));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset value of the limit, then directed points at that limit
        apb_xfer(1'b0, '0);
        push_point('0, '0);                       // fixed point at zero returns to c
        push_point(-Q_ONE, '0);                   // period two returns to c
        push_point(Z_TOP, Z_TOP);                 // format extremes escape at once
        push_point(Z_BOTTOM, Z_BOTTOM);
        push_point(Z_BOTTOM, Z_TOP);
        push_point(4 * Q_ONE, '0);                // exactly on the radius
        push_point(4 * Q_ONE + 1, '0);            // one step past the radius
        push_point('0, -(4 * Q_ONE));
        push_point(-(4 * Q_ONE), '0);
        push_point(-(2 * Q_ONE), '0);             // lands on 2 and stays
        push_point('0, Q_ONE);                    // cycles without returning to c
        push_point('1, '1);                       // smallest negative steps
        push_point(mbe_pkg::z_t'(1), '0);
        push_point(Q_ONE / 4, '0);                // slow parabolic approach

        // Zero limit: at most one step
        set_limit('0);
        push_point('0, '0);
        push_point(-Q_ONE, '0);
        push_point(Q_ONE, '0);
        push_point(5 * Q_ONE, '0);

        set_limit(mbe_pkg::cfg_t'(1));
        push_point(-Q_ONE, '0);
        push_point('0, '0);
        push_point(-(2 * Q_ONE), '0);

        // Random points over a sweep of small limits
        for (int p = 0; p < SWEEP_PHASES; p++)
        begin
            set_limit(sweep_limits[p]);
            push_random(SWEEP_POINTS, 1'b0);
        end

        set_limit(mbe_pkg::MAX_ITER_RESET);
        push_random(25, 1'b0);

        // Largest limit: only points that leave quickly
        set_limit('1);
        push_random(40, 1'b1);

        quiesce();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d points over %0d limit settings, 0 and 65535 among them.",
                 points_sent, limits_set);
        $display("%0d orbits closed back onto c at the limit; %0d mismatches counted.",
                 returns_seen, mismatches);
        if (mismatches == 0 && pending_results == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
